// ===== rtl/ple_pkg.sv =====
`default_nettype none

package ple_pkg;

	localparam int CAPACITY   = 64;
	localparam int ELEM_WIDTH = 32;
	localparam int POS_W      = 7;
	localparam int CNT_W      = $clog2(CAPACITY + 1);
	localparam int GRP_SIZE   = 8;
	localparam int NGRP       = (CAPACITY + GRP_SIZE - 1) / GRP_SIZE;

	typedef enum logic [1:0] {
		KIND_INSERT = 2'd0,
		KIND_REMOVE = 2'd1,
		KIND_GET    = 2'd2,
		KIND_NONE   = 2'd3
	} ple_kind_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_FULL   = 2'd1,
		ST_EMPTY  = 2'd2,
		ST_BADPOS = 2'd3
	} ple_status_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [6:0]  position;
		logic [31:0] element_value;
	} ple_req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] read_value;
		logic [6:0]  entry_count;
	} ple_rsp_t;

	typedef struct packed {
		logic                  ins;
		logic                  rem;
		logic                  rd;
		logic [POS_W-1:0]      pos;
		logic [ELEM_WIDTH-1:0] elem;
	} ple_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/ple_cell.sv =====
`default_nettype none

module ple_cell
	import ple_pkg::*;
#(
	parameter int IDX = 0
) (
	input  wire logic                  clk,
	input  wire ple_ctrl_t             ctrl,
	input  wire logic [ELEM_WIDTH-1:0] left,
	input  wire logic [ELEM_WIDTH-1:0] right,
	output logic      [ELEM_WIDTH-1:0] data,
	output logic      [ELEM_WIDTH-1:0] rd
);

	localparam logic [POS_W-1:0] MY_POS = POS_W'(IDX);

	logic [ELEM_WIDTH-1:0] data_q;

	always_ff @(posedge clk) begin
		if (ctrl.ins) begin
			if (MY_POS > ctrl.pos) begin
				data_q <= left;
			end else if (MY_POS == ctrl.pos) begin
				data_q <= ctrl.elem;
			end
		end else if (ctrl.rem) begin
			if (MY_POS >= ctrl.pos) begin
				data_q <= right;
			end
		end
	end

	assign data = data_q;
	assign rd   = (ctrl.rd && (MY_POS == ctrl.pos)) ? data_q : '0;

endmodule

`default_nettype wire

// ===== rtl/positional_list_engine_top.sv =====
`default_nettype none

// Requests pass the stage-one register and then the response register.
// New requests stall while stage one is busy or a response is held; stage one
// keeps the group ORs of the tree that collects the read word from the cell row.
// Inserts and removes update the cells at and above the given position together.
// Reset clears the entry count and the valid flags; cell contents are not cleared.

module positional_list_engine_top
	import ple_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     req_valid,
	output logic          req_stall,
	input  wire ple_req_t req,
	output logic          rsp_valid,
	input  wire logic     rsp_stall,
	output ple_rsp_t      rsp
);

	logic [CNT_W-1:0]      cnt_q;
	logic                  valid_s1;
	logic [1:0]            status_s1;
	logic [CNT_W-1:0]      cnt_s1;
	logic [ELEM_WIDTH-1:0] grp_s1 [NGRP];
	logic                  rsp_valid_q;
	ple_rsp_t              rsp_q;

	logic                  accept;
	logic                  move;
	logic                  do_ins;
	logic                  do_rem;
	logic                  do_rd;
	logic [1:0]            status_d;
	logic [CNT_W-1:0]      cnt_d;
	ple_ctrl_t             ctrl;
	logic [ELEM_WIDTH-1:0] cell_data [CAPACITY];
	logic [ELEM_WIDTH-1:0] cell_rd   [CAPACITY];
	logic [ELEM_WIDTH-1:0] grp_d     [NGRP];
	logic [ELEM_WIDTH-1:0] rd_all;
	logic [CNT_W-1:0]      pos_c;

	assign req_stall = valid_s1 || (rsp_valid_q && rsp_stall);
	assign accept    = req_valid && !req_stall;
	assign move      = valid_s1 && !(rsp_valid_q && rsp_stall);
	assign pos_c     = CNT_W'(req.position);

	always_comb begin
		do_ins   = 1'b0;
		do_rem   = 1'b0;
		do_rd    = 1'b0;
		status_d = ST_BADPOS;
		cnt_d    = cnt_q;
		case (req.kind)
			KIND_INSERT: begin
				if (cnt_q == CNT_W'(CAPACITY)) begin
					status_d = ST_FULL;
				end else if (pos_c > cnt_q) begin
					status_d = ST_BADPOS;
				end else begin
					status_d = ST_OK;
					do_ins   = 1'b1;
					cnt_d    = cnt_q + CNT_W'(1);
				end
			end
			KIND_REMOVE, KIND_GET: begin
				if (cnt_q == '0) begin
					status_d = ST_EMPTY;
				end else if (pos_c >= cnt_q) begin
					status_d = ST_BADPOS;
				end else begin
					status_d = ST_OK;
					if (req.kind == KIND_REMOVE) begin
						do_rem = 1'b1;
						cnt_d  = cnt_q - CNT_W'(1);
					end else begin
						do_rd = 1'b1;
					end
				end
			end
			default: begin
				status_d = ST_BADPOS;
			end
		endcase
	end

	assign ctrl.ins  = accept && do_ins;
	assign ctrl.rem  = accept && do_rem;
	assign ctrl.rd   = do_rd;
	assign ctrl.pos  = req.position;
	assign ctrl.elem = ELEM_WIDTH'(req.element_value);

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [ELEM_WIDTH-1:0] left_w;
		logic [ELEM_WIDTH-1:0] right_w;
		if (i == 0) begin : g_first
			assign left_w = '0;
		end else begin : g_mid_l
			assign left_w = cell_data[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign right_w = '0;
		end else begin : g_mid_r
			assign right_w = cell_data[i+1];
		end
		ple_cell #(
			.IDX(i)
		) u_cell (
			.clk  (clk),
			.ctrl (ctrl),
			.left (left_w),
			.right(right_w),
			.data (cell_data[i]),
			.rd   (cell_rd[i])
		);
	end

	always_comb begin
		for (int g = 0; g < NGRP; g++) begin
			grp_d[g] = '0;
			for (int k = 0; k < GRP_SIZE; k++) begin
				if (g * GRP_SIZE + k < CAPACITY) begin
					grp_d[g] = grp_d[g] | cell_rd[g * GRP_SIZE + k];
				end
			end
		end
	end

	always_comb begin
		rd_all = '0;
		for (int g = 0; g < NGRP; g++) begin
			rd_all = rd_all | grp_s1[g];
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_s1 <= status_d;
			cnt_s1    <= cnt_d;
			for (int g = 0; g < NGRP; g++) begin
				grp_s1[g] <= grp_d[g];
			end
		end
		if (move) begin
			rsp_q.status      <= status_s1;
			rsp_q.read_value  <= 32'(rd_all);
			rsp_q.entry_count <= 7'(cnt_s1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			valid_s1    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				cnt_q <= cnt_d;
			end
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (move) begin
				valid_s1 <= 1'b0;
			end
			if (move) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`ifndef ASSERT_OFF
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(CAPACITY))
		else $error("entry count above capacity");

	a_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> cnt_q == $past(cnt_q))
		else $error("entry count changed without a request");

	a_s1_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !(rsp_valid_q && rsp_stall)) |=> (rsp_valid_q && !valid_s1))
		else $error("stage one did not drain into the response register");

	a_rd_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && rsp_q.status != ST_OK) |-> rsp_q.read_value == '0)
		else $error("read value set on a failed request");
`endif

endmodule

`default_nettype wire

// ===== verif/positional_list_engine_top_test.sv =====
`timescale 1ns / 1ps

module positional_list_engine_top_test
	import ple_pkg::*;
();

	localparam int QUIET_LIMIT = 2000;
	localparam int ROWS        = 20;
	localparam int REQ_W       = $bits(ple_req_t);

	typedef struct packed {
		ple_req_t rq;
		logic     typed;
		ple_rsp_t rs;
	} script_row_t;

	logic     clk;
	logic     arst_n;
	logic     req_valid;
	logic     req_stall;
	ple_req_t req;
	logic     rsp_valid;
	logic     rsp_stall;
	ple_rsp_t rsp;

	logic [ELEM_WIDTH-1:0] list_words [CAPACITY];
	int unsigned           list_fill;
	ple_rsp_t              awaited_results [$];
	script_row_t           script [ROWS];
	int                    mismatches;
	int                    idle_level;
	int                    stall_run;
	int                    quiet_cycles;

	positional_list_engine_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic ple_rsp_t list_apply(input ple_req_t r);
		ple_rsp_t o;
		int       i;
		o = '0;
		o.status = ST_OK;
		case (ple_kind_t'(r.kind))
			KIND_INSERT: begin
				if (list_fill >= CAPACITY) begin
					o.status = ST_FULL;
				end else if (r.position > list_fill) begin
					o.status = ST_BADPOS;
				end else begin
					for (i = list_fill; i > r.position; i--)
						list_words[i] = list_words[i-1];
					list_words[r.position] = r.element_value;
					list_fill++;
				end
			end
			KIND_REMOVE, KIND_GET: begin
				if (list_fill == 0) begin
					o.status = ST_EMPTY;
				end else if (r.position >= list_fill) begin
					o.status = ST_BADPOS;
				end else if (ple_kind_t'(r.kind) == KIND_GET) begin
					o.read_value = list_words[r.position];
				end else begin
					for (i = r.position; i + 1 < list_fill; i++)
						list_words[i] = list_words[i+1];
					list_fill--;
				end
			end
			default: o.status = ST_BADPOS;
		endcase
		o.entry_count = 7'(list_fill);
		return o;
	endfunction

	function automatic int idle_gap();
		int r;
		r = $urandom_range(0, 99);
		case (idle_level)
			0: return 0;
			1: begin
				if (r < 75) return 0;
				if (r < 97) return $urandom_range(1, 3);
				return $urandom_range(4, 20);
			end
			default: begin
				if (r < 40) return 0;
				if (r < 85) return $urandom_range(1, 4);
				return $urandom_range(5, 24);
			end
		endcase
	endfunction

	function automatic ple_req_t random_request(input int ins_weight);
		ple_req_t r;
		int       k;
		int       p;
		k = $urandom_range(0, 99);
		p = $urandom_range(0, 99);
		if (k < 2)
			r.kind = KIND_NONE;
		else if (k < ins_weight)
			r.kind = KIND_INSERT;
		else if (k < ins_weight + (100 - ins_weight) / 2)
			r.kind = KIND_REMOVE;
		else
			r.kind = KIND_GET;
		if (p < 85)
			r.position = 7'($urandom_range(0, list_fill));
		else if (p < 95)
			r.position = 7'($urandom_range(0, 127));
		else if (p < 98)
			r.position = 7'(CAPACITY);
		else
			r.position = 7'd127;
		r.element_value = $urandom;
		return r;
	endfunction

	task automatic note_error(input string what, input ple_rsp_t want, input ple_rsp_t got);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t: %s: status %0d/%0d read %h/%h count %0d/%0d", $realtime, what,
				want.status, got.status, want.read_value, got.read_value,
				want.entry_count, got.entry_count);
	endtask

	task automatic push_request(input ple_req_t r, input logic typed, input ple_rsp_t typed_rs);
		ple_rsp_t predicted;
		int       gap;
		gap = idle_gap();
		repeat (gap) begin
			@(negedge clk);
			req_valid <= 1'b0;
			req       <= REQ_W'({$urandom, $urandom});
			@(posedge clk);
		end
		@(negedge clk);
		req_valid <= 1'b1;
		req       <= r;
		do @(posedge clk); while (req_stall);
		predicted = list_apply(r);
		awaited_results.push_back(typed ? typed_rs : predicted);
	endtask

	always @(negedge clk) begin
		if (!arst_n) begin
			rsp_stall <= 1'b0;
		end else begin
			if (stall_run == 0)
				stall_run = idle_gap();
			rsp_stall <= (stall_run != 0);
			if (stall_run != 0)
				stall_run--;
		end
	end

	always @(posedge clk) begin
		ple_rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (awaited_results.size() == 0) begin
				note_error("response with none awaited", '0, rsp);
			end else begin
				want = awaited_results.pop_front();
				if (rsp.status !== want.status || rsp.read_value !== want.read_value ||
				    rsp.entry_count !== want.entry_count)
					note_error("mismatch", want, rsp);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("positional_list_engine_top_test failed");
				$finish;
			end
		end
	end

	initial begin
		int ph;
		int n;
		int weights [3];
		arst_n       = 1'b0;
		req_valid    = 1'b0;
		req          = '0;
		rsp_stall    = 1'b0;
		mismatches   = 0;
		idle_level   = 1;
		stall_run    = 0;
		quiet_cycles = 0;
		list_fill    = 0;
		weights      = '{80, 25, 55};
		foreach (list_words[i])
			list_words[i] = '0;
		script = '{
			'{'{KIND_GET,    7'd0,   32'h0},         1'b1, '{ST_EMPTY,  32'h0,         7'd0}},
			'{'{KIND_REMOVE, 7'd0,   32'h0},         1'b1, '{ST_EMPTY,  32'h0,         7'd0}},
			'{'{KIND_INSERT, 7'd1,   32'hDEAD_BEEF}, 1'b1, '{ST_BADPOS, 32'h0,         7'd0}},
			'{'{KIND_INSERT, 7'd0,   32'hFFFF_FFFF}, 1'b1, '{ST_OK,     32'h0,         7'd1}},
			'{'{KIND_INSERT, 7'd0,   32'h0},         1'b1, '{ST_OK,     32'h0,         7'd2}},
			'{'{KIND_INSERT, 7'd2,   32'hA5A5_5A5A}, 1'b1, '{ST_OK,     32'h0,         7'd3}},
			'{'{KIND_GET,    7'd0,   32'hFFFF_FFFF}, 1'b1, '{ST_OK,     32'h0,         7'd3}},
			'{'{KIND_GET,    7'd1,   32'h0},         1'b1, '{ST_OK,     32'hFFFF_FFFF, 7'd3}},
			'{'{KIND_GET,    7'd3,   32'h0},         1'b1, '{ST_BADPOS, 32'h0,         7'd3}},
			'{'{KIND_GET,    7'd127, 32'h0},         1'b1, '{ST_BADPOS, 32'h0,         7'd3}},
			'{'{KIND_NONE,   7'd0,   32'h1234_5678}, 1'b1, '{ST_BADPOS, 32'h0,         7'd3}},
			'{'{KIND_INSERT, 7'd1,   32'h1234_5678}, 1'b1, '{ST_OK,     32'h0,         7'd4}},
			'{'{KIND_REMOVE, 7'd4,   32'h0},         1'b1, '{ST_BADPOS, 32'h0,         7'd4}},
			'{'{KIND_REMOVE, 7'd1,   32'h0},         1'b0, '0},
			'{'{KIND_GET,    7'd1,   32'h0},         1'b0, '0},
			'{'{KIND_GET,    7'd2,   32'h0},         1'b0, '0},
			'{'{KIND_REMOVE, 7'd2,   32'h0},         1'b0, '0},
			'{'{KIND_REMOVE, 7'd0,   32'h0},         1'b0, '0},
			'{'{KIND_REMOVE, 7'd0,   32'hFFFF_FFFF}, 1'b0, '0},
			'{'{KIND_GET,    7'd0,   32'h0},         1'b1, '{ST_EMPTY,  32'h0,         7'd0}}
		};
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (script[i])
			push_request(script[i].rq, script[i].typed, script[i].rs);

		for (ph = 0; ph < 12; ph++) begin
			idle_level = ph % 3;
			for (n = 0; n < 120; n++)
				push_request(random_request(weights[ph % 3]), 1'b0, '0);
		end

		@(negedge clk);
		req_valid <= 1'b0;
		while (awaited_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("positional_list_engine_top_test passed");
		else
			$display("positional_list_engine_top_test failed");
		$finish;
	end

endmodule

// ===== positional_list_engine_top.f =====
rtl/ple_pkg.sv
rtl/ple_cell.sv
rtl/positional_list_engine_top.sv
verif/positional_list_engine_top_test.sv
